// ===== src/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants for the frame receiver.
// Holds the receive phase encoding, event codes, sync constants and the
// structs that carry receiver state and one result.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

	localparam logic [7:0] SYNC_FIRST    = 8'hA5;
	localparam logic [7:0] SYNC_SECOND   = 8'h5A;
	localparam logic [7:0] MAX_LEN_RESET = 8'd160;

	// Receive phase; the two unused codes behave like the first sync hunt.
	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_TYPE  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_DATA    = 3'd1,
		EV_GOOD    = 3'd2,
		EV_BADSUM  = 3'd3,
		EV_TOOLONG = 3'd4
	} event_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] held_type;
		logic [7:0] held_length;
		logic [7:0] byte_position;
		logic [7:0] running_xor;
	} rx_state_t;

	typedef struct packed {
		event_t     ev;
		logic [7:0] pkt_type;
		logic [7:0] frame_length;
		logic [7:0] payload_byte;
		logic [7:0] byte_index;
	} result_t;

endpackage

`default_nettype wire

// ===== src/frame_receiver_xor_checksum.sv =====
// A byte accepted into the input register has its result transaction loaded
// into the result register once that register is empty or draining.
// Throughput: one byte per cycle while out_stall is low; the state update is one pass through frc_step.
// Reset clears both pipeline stages, the receiver goes to the first sync hunt
// and the maximum payload length returns to 160.
// ----------------------------------------------------------------------------
// frame_receiver_xor_checksum: sync-word framed receiver with XOR check.
// Hunts for 0xA5 0x5A, reads type and length, streams payload bytes with
// their index and reports good frame, checksum error or over-long frame.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receiver_xor_checksum (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      event_res,
	output logic [7:0]      pkt_type,
	output logic [7:0]      frame_length,
	output logic [7:0]      payload_byte,
	output logic [7:0]      byte_index
);
	import frc_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       valid_s2;
	result_t    result_s2;
	rx_state_t  state_q;
	rx_state_t  state_next;
	result_t    result_next;
	logic [7:0] max_len_q;
	logic       load_s2;
	logic       load_s1;

	// Pipeline flow control: stage 2 loads when empty or drained.
	assign load_s2  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	frc_step u_step (
		.state      (state_q),
		.rx_byte    (rx_byte_s1),
		.max_len    (max_len_q),
		.state_next (state_next),
		.result     (result_next)
	);

	// Receiver state advances once per byte moved into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_HUNT0, default: '0};
		end else if (load_s2) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid    = valid_s2;
	assign event_res    = result_s2.ev;
	assign pkt_type     = result_s2.pkt_type;
	assign frame_length = result_s2.frame_length;
	assign payload_byte = result_s2.payload_byte;
	assign byte_index   = result_s2.byte_index;

endmodule

`default_nettype wire

// ===== src/frc_step.sv =====
// ----------------------------------------------------------------------------
// frc_step: per-byte deframing step.
// Given the current receiver state and one received byte, computes the next
// state and the single result the byte produces.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_step (
	input  wire frc_pkg::rx_state_t state,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [7:0]         max_len,
	output frc_pkg::rx_state_t      state_next,
	output frc_pkg::result_t        result
);
	import frc_pkg::*;

	logic [7:0] pos_inc;

	assign pos_inc = state.byte_position + 8'd1;

	// Next state and result for one byte.
	always_comb begin
		state_next = state;
		result     = '0;
		result.ev  = EV_NONE;
		unique case (state.phase)
			PH_HUNT1: begin
				state_next.phase = (rx_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT0;
			end
			PH_TYPE: begin
				state_next.held_type   = rx_byte;
				state_next.running_xor = rx_byte;
				state_next.phase       = PH_LEN;
			end
			PH_LEN: begin
				state_next.held_length   = rx_byte;
				state_next.byte_position = '0;
				state_next.running_xor   = state.running_xor ^ rx_byte;
				if (rx_byte > max_len) begin
					state_next.phase    = PH_HUNT0;
					result.ev           = EV_TOOLONG;
					result.pkt_type     = state.held_type;
					result.frame_length = rx_byte;
				end else begin
					state_next.phase = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				result.ev                = EV_DATA;
				result.pkt_type          = state.held_type;
				result.frame_length      = state.held_length;
				result.payload_byte      = rx_byte;
				result.byte_index        = state.byte_position;
				state_next.running_xor   = state.running_xor ^ rx_byte;
				state_next.byte_position = pos_inc;
				if (pos_inc >= state.held_length) begin
					state_next.phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				state_next.phase    = PH_HUNT0;
				result.ev           = (rx_byte == state.running_xor) ? EV_GOOD : EV_BADSUM;
				result.pkt_type     = state.held_type;
				result.frame_length = state.held_length;
			end
			default: begin
				// First sync hunt; unused phase codes fall here as well.
				state_next.phase = (rx_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== test/frame_receiver_xor_checksum_tb.sv =====
// ----------------------------------------------------------------------------
// frame_receiver_xor_checksum_tb: self-checking bench for the frame receiver.
// Feeds link bytes through the input channel, predicts the event for every
// accepted byte with a local deframer model and compares each output
// transaction in order. Covers sync hunting, length limits, checksums and
// heavy back-pressure on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receiver_xor_checksum_tb;

	import frc_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 36;
	localparam int RANDOM_BYTES  = 900;
	localparam int SETTLE_CYCLES = 6;
	localparam int REPORT_LIMIT  = 10;
	localparam int HOLD_CYCLES   = 80;
	localparam int FULL_FRAME    = 256;
	localparam int TIMEOUT       = 2_000_000;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte     = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [2:0] event_res;
	logic [7:0] pkt_type;
	logic [7:0] frame_length;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;

	// Local copy of the receiver state and its one register.
	phase_t     rx_phase_m    = PH_HUNT0;
	logic [7:0] held_type_m   = 8'd0;
	logic [7:0] held_length_m = 8'd0;
	logic [7:0] position_m    = 8'd0;
	logic [7:0] xor_m         = 8'd0;
	logic [7:0] max_length_m  = MAX_LEN_RESET;

	result_t pending_events[$];
	int      event_tally[5];
	int      framed_bytes;
	int      sent_bytes;
	int      error_count;
	int      report_count;
	int      hold_request;
	int      hold_left;
	bit      no_idle;

	frame_receiver_xor_checksum u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.pkt_type     (pkt_type),
		.frame_length (frame_length),
		.payload_byte (payload_byte),
		.byte_index   (byte_index)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Advances the local deframer by one byte and returns the event it reports.
	function automatic result_t deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		sent_bytes++;
		// Bytes dropped while hunting for the first sync byte do not count.
		if (!(rx_phase_m == PH_HUNT0 && b != SYNC_FIRST))
			framed_bytes++;
		case (rx_phase_m)
			PH_HUNT1: rx_phase_m = (b == SYNC_SECOND) ? PH_TYPE : PH_HUNT0;
			PH_TYPE: begin
				held_type_m = b;
				xor_m       = b;
				rx_phase_m  = PH_LEN;
			end
			PH_LEN: begin
				held_length_m = b;
				position_m    = 8'd0;
				xor_m         = xor_m ^ b;
				if (b > max_length_m) begin
					rx_phase_m     = PH_HUNT0;
					r.ev           = EV_TOOLONG;
					r.pkt_type     = held_type_m;
					r.frame_length = held_length_m;
				end else begin
					rx_phase_m = (b == 8'd0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				r.ev           = EV_DATA;
				r.pkt_type     = held_type_m;
				r.frame_length = held_length_m;
				r.payload_byte = b;
				r.byte_index   = position_m;
				xor_m          = xor_m ^ b;
				position_m     = position_m + 8'd1;
				if (position_m >= held_length_m)
					rx_phase_m = PH_CHECK;
			end
			PH_CHECK: begin
				rx_phase_m     = PH_HUNT0;
				r.ev           = (b == xor_m) ? EV_GOOD : EV_BADSUM;
				r.pkt_type     = held_type_m;
				r.frame_length = held_length_m;
			end
			default: rx_phase_m = (b == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
		endcase
		event_tally[r.ev]++;
		return r;
	endfunction

	// Offers one byte until it is taken, records its event, then maybe idles.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_events.push_back(deframe_byte(b));
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends sync, type and length, then payload and check byte. A frame whose
	// length is over the limit stops after the length byte; a keep count below
	// the length abandons the frame part way through its payload.
	task automatic send_packet(input logic [7:0] typ, input logic [7:0] len,
			input bit corrupt, input int keep);
		logic [7:0] chk;
		logic [7:0] b;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(typ);
		send_byte(len);
		chk = typ ^ len;
		if (len > max_length_m)
			return;
		for (int i = 0; i < len; i++) begin
			if (i == keep)
				return;
			b   = 8'($urandom);
			chk = chk ^ b;
			send_byte(b);
		end
		if (corrupt)
			chk = chk ^ 8'($urandom_range(1, 255));
		send_byte(chk);
	endtask

	// Stops offering and waits until every expected transaction has arrived.
	task automatic wait_all_results;
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [7:0] value);
		wait_all_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		max_length_m  = value;
	endtask

	// Noise, sync edge cases, an empty frame, a bad checksum and an over-long
	// length at the reset limit.
	task automatic test_directed;
		send_byte(8'h00);
		send_byte(8'hFF);
		// A first sync byte in the second sync slot must not restart the pair.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_packet(8'h00, 8'd0, 1'b0, FULL_FRAME);
		send_packet(8'hFF, 8'd2, 1'b1, FULL_FRAME);
		send_packet(SYNC_SECOND, MAX_LEN_RESET + 8'd1, 1'b0, FULL_FRAME);
	endtask

	// Limits at both extremes and just around a small value.
	task automatic test_length_limits;
		write_max_length(8'd0);
		send_packet(8'h3C, 8'd0, 1'b0, FULL_FRAME);
		send_packet(8'hC3, 8'd1, 1'b0, FULL_FRAME);
		write_max_length(8'd255);
		send_packet(8'h81, 8'd255, 1'b0, FULL_FRAME);
		write_max_length(8'd3);
		send_packet(8'h7E, 8'd3, 1'b0, FULL_FRAME);
		send_packet(8'h18, 8'd4, 1'b0, FULL_FRAME);
		write_max_length(MAX_LEN_RESET);
	endtask

	// A long run of frames with neither side idling.
	task automatic test_back_to_back;
		no_idle = 1'b1;
		repeat (12)
			send_packet(8'($urandom), 8'($urandom_range(0, 10)),
				$urandom_range(0, 3) == 0, FULL_FRAME);
		no_idle = 1'b0;
	endtask

	// The output side holds off while the sender keeps offering a long frame.
	task automatic test_output_hold;
		wait_all_results();
		hold_request = HOLD_CYCLES;
		no_idle      = 1'b1;
		send_packet(8'($urandom), 8'd40, 1'b0, FULL_FRAME);
		no_idle      = 1'b0;
	endtask

	// The sender pauses mid-stream until the block has delivered everything.
	task automatic test_sender_pause;
		send_packet(8'($urandom), 8'd5, 1'b0, FULL_FRAME);
		wait_all_results();
		send_packet(8'($urandom), 8'd6, 1'b1, 3);
		wait_all_results();
		send_packet(8'($urandom), 8'd2, 1'b0, FULL_FRAME);
	endtask

	// Mostly well-formed frames with random content, the rest broken frames,
	// stray sync bytes and noise.
	task automatic run_random_traffic(input int count);
		int   stop_at;
		int   pick;
		logic [7:0] len;
		stop_at = framed_bytes + count;
		while (framed_bytes < stop_at) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 7)
				len = 8'($urandom_range(0, 8));
			else if ($urandom_range(0, 2) != 0)
				len = 8'($urandom_range(9, 40));
			else
				len = 8'($urandom_range(0, 255));
			if (pick < 70)
				send_packet(8'($urandom), len, $urandom_range(0, 3) == 0, FULL_FRAME);
			else if (pick < 80)
				send_packet(8'($urandom), len, 1'b0,
					(len == 8'd0) ? 0 : int'($urandom_range(0, len - 1)));
			else if (pick < 88) begin
				send_byte(SYNC_FIRST);
				send_byte(8'($urandom));
			end else if (pick < 92) begin
				send_byte(SYNC_FIRST);
				send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
			if ($urandom_range(0, 99) < 3)
				wait_all_results();
		end
	endtask

	task automatic test_random_traffic;
		write_max_length(8'($urandom_range(1, 254)));
		run_random_traffic(RANDOM_BYTES / 3);
		write_max_length(8'd255);
		run_random_traffic(RANDOM_BYTES / 3);
		write_max_length(MAX_LEN_RESET);
		run_random_traffic(RANDOM_BYTES / 3);
	endtask

	// Output side: random stalls, a counted hold-off on request, none in bursts.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Compares every accepted output transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				error_count++;
				if (report_count < REPORT_LIMIT)
					$display("Unexpected transaction: event %0d type %0h len %0d",
						event_res, pkt_type, frame_length);
				report_count++;
			end else begin
				want = pending_events.pop_front();
				if (event_res !== want.ev || pkt_type !== want.pkt_type ||
						frame_length !== want.frame_length ||
						payload_byte !== want.payload_byte ||
						byte_index !== want.byte_index) begin
					error_count++;
					if (report_count < REPORT_LIMIT)
						$display({"Mismatch: expected ev %0d type %0h len %0d byte %0h idx %0d,",
							" got ev %0d type %0h len %0d byte %0h idx %0d"},
							want.ev, want.pkt_type, want.frame_length,
							want.payload_byte, want.byte_index, event_res, pkt_type,
							frame_length, payload_byte, byte_index);
					report_count++;
				end
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_length_limits();
		test_back_to_back();
		test_output_hold();
		test_sender_pause();
		test_random_traffic();
		wait_all_results();
		$display("Sent %0d bytes: %0d good frames, %0d checksum errors, %0d over-limit lengths,",
			sent_bytes, event_tally[EV_GOOD], event_tally[EV_BADSUM],
			event_tally[EV_TOOLONG]);
		$display("%0d payload bytes; limits 0, 3, 255, 160 and random; %0d errors.",
			event_tally[EV_DATA], error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#TIMEOUT;
		$display("Timeout with %0d transactions outstanding", pending_events.size());
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/frc_pkg.sv
src/frc_step.sv
src/frame_receiver_xor_checksum.sv
test/frame_receiver_xor_checksum_tb.sv
